// ===== rtl/qawn_pkg.sv =====
// Shared types, constants and character helpers for the whitespace normalizer.
`timescale 1ns / 1ps
`default_nettype none

package qawn_pkg;

  localparam int CHAR_W         = 8;
  localparam int PEND_DEPTH_DEF = 8;

  localparam logic [CHAR_W-1:0] CHAR_DQUOTE = 8'h22;
  localparam logic [CHAR_W-1:0] CHAR_SQUOTE = 8'h27;

  typedef enum logic [1:0] {
    Q_NONE   = 2'd0,
    Q_DOUBLE = 2'd1,
    Q_SINGLE = 2'd2
  } quote_t;

  typedef enum logic [1:0] {
    S_IDLE  = 2'd0,
    S_DRAIN = 2'd1,
    S_EVICT = 2'd2,
    S_CHAR  = 2'd3
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic take;       // latch the accepted request
    logic ws_reset;   // held whitespace becomes this single byte
    logic ws_append;  // append this byte to the held whitespace
    logic rd;         // read a held byte
    logic rd_next;    // read the entry after the head instead of the head
    logic pop;        // send the head byte and drop it
    logic evict;      // send the head byte and overwrite it with the latched byte
    logic emit;       // send the latched byte or a bare end marker
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic in_ws;      // incoming byte is whitespace
    logic seen;       // content seen in this string
    logic quoted;     // inside a quoted span
    logic cnt_zero;
    logic cnt_one;
    logic full;
    logic push_ok;    // output register can take a byte this cycle
  } sts_t;

  function automatic logic is_ws(input logic [CHAR_W-1:0] c);
    return c inside {8'd32, [8'd9:8'd13]};
  endfunction

  function automatic logic [CHAR_W-1:0] to_lower(input logic [CHAR_W-1:0] c);
    logic [CHAR_W-1:0] r;
    r = c;
    if (c inside {[8'd65:8'd90]}) begin
      r = c + 8'd32;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/qawn_in_if.sv =====
// Input channel interface: one raw byte per request with an end-of-string flag.
`timescale 1ns / 1ps
`default_nettype none

interface qawn_in_if;
  logic                         valid;
  logic                         ready;
  logic [qawn_pkg::CHAR_W-1:0]  in_char;
  logic                         in_last;

  modport source (output valid, output in_char, output in_last, input ready);
  modport sink   (input valid, input in_char, input in_last, output ready);
endinterface

`default_nettype wire

// ===== rtl/qawn_out_if.sv =====
// Result channel interface: one normalized byte or end marker per request.
`timescale 1ns / 1ps
`default_nettype none

interface qawn_out_if;
  logic                         valid;
  logic                         ready;
  logic [qawn_pkg::CHAR_W-1:0]  out_char;
  logic                         has_char;
  logic                         out_last;

  modport source (output valid, output out_char, output has_char, output out_last,
                  input ready);
  modport sink   (input valid, input out_char, input has_char, input out_last,
                  output ready);
endinterface

`default_nettype wire

// ===== rtl/qawn_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module qawn_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/qawn_ctrl.sv =====
// Controller state machine: sequences accept, drain, evict and byte output.
`timescale 1ns / 1ps
`default_nettype none

module qawn_ctrl (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  input  wire logic            in_last,
  input  wire qawn_pkg::sts_t  sts,
  output logic                 in_ready,
  output qawn_pkg::cmd_t       cmd
);

  qawn_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= qawn_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      qawn_pkg::S_IDLE: begin
        if (in_valid) begin
          if (sts.in_ws) begin
            if (in_last) begin
              state_nxt = qawn_pkg::S_CHAR;
            end else if (sts.seen && sts.quoted && sts.full) begin
              state_nxt = qawn_pkg::S_EVICT;
            end
          end else if (sts.cnt_zero) begin
            state_nxt = qawn_pkg::S_CHAR;
          end else begin
            state_nxt = qawn_pkg::S_DRAIN;
          end
        end
      end
      qawn_pkg::S_DRAIN: begin
        if (sts.push_ok && sts.cnt_one) begin
          state_nxt = qawn_pkg::S_CHAR;
        end
      end
      qawn_pkg::S_EVICT: begin
        if (sts.push_ok) begin
          state_nxt = qawn_pkg::S_IDLE;
        end
      end
      qawn_pkg::S_CHAR: begin
        if (sts.push_ok) begin
          state_nxt = qawn_pkg::S_IDLE;
        end
      end
      default: state_nxt = qawn_pkg::S_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state_r)
      qawn_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.take = 1'b1;
          if (sts.in_ws) begin
            if (!in_last && sts.seen) begin
              if (!sts.quoted) begin
                cmd.ws_reset = 1'b1;
              end else if (sts.full) begin
                cmd.rd = 1'b1;
              end else begin
                cmd.ws_append = 1'b1;
              end
            end
          end else if (!sts.cnt_zero) begin
            cmd.rd = 1'b1;
          end
        end
      end
      qawn_pkg::S_DRAIN: begin
        if (sts.push_ok) begin
          cmd.pop = 1'b1;
          if (!sts.cnt_one) begin
            cmd.rd      = 1'b1;
            cmd.rd_next = 1'b1;
          end
        end
      end
      qawn_pkg::S_EVICT: begin
        cmd.evict = sts.push_ok;
      end
      qawn_pkg::S_CHAR: begin
        cmd.emit = sts.push_ok;
      end
      default: begin
        cmd      = '0;
        in_ready = 1'b0;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/qawn_dp.sv =====
// Datapath: quote and content state, held-whitespace queue and output register.
`timescale 1ns / 1ps
`default_nettype none

module qawn_dp #(
  parameter int PEND_DEPTH = qawn_pkg::PEND_DEPTH_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire qawn_pkg::cmd_t              cmd,
  input  wire logic [qawn_pkg::CHAR_W-1:0] in_char,
  input  wire logic                        in_last,
  input  wire logic                        out_ready,
  output qawn_pkg::sts_t                   sts,
  output logic                             out_valid,
  output logic      [qawn_pkg::CHAR_W-1:0] out_char,
  output logic                             has_char,
  output logic                             out_last
);

  localparam int PW = (PEND_DEPTH > 1) ? $clog2(PEND_DEPTH) : 1;
  localparam int CW = $clog2(PEND_DEPTH + 1);

  logic [qawn_pkg::CHAR_W-1:0] char_r;
  logic                        last_r;
  qawn_pkg::quote_t            quote_r, quote_nxt, quote_upd;
  logic                        seen_r, seen_nxt;
  logic [PW-1:0]               head_r, head_nxt, head_inc, tail;
  logic [CW-1:0]               cnt_r, cnt_nxt;
  logic [CW:0]                 tail_sum;
  logic                        ov_r, ov_nxt;
  logic [qawn_pkg::CHAR_W-1:0] oc_r, oc_nxt;
  logic                        oh_r, oh_nxt;
  logic                        ol_r, ol_nxt;

  logic                        we;
  logic [PW-1:0]               waddr, raddr;
  logic [qawn_pkg::CHAR_W-1:0] wdata, rdata;
  logic                        char_has;

  qawn_ram #(
    .WIDTH (qawn_pkg::CHAR_W),
    .DEPTH (PEND_DEPTH)
  ) u_pend_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (cmd.rd),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign head_inc = (head_r == PW'(PEND_DEPTH - 1)) ? '0 : head_r + PW'(1);
  assign tail_sum = (CW+1)'(head_r) + (CW+1)'(cnt_r);
  assign tail     = (tail_sum >= (CW+1)'(PEND_DEPTH)) ?
                    PW'(tail_sum - (CW+1)'(PEND_DEPTH)) : PW'(tail_sum);

  assign raddr = cmd.rd_next ? head_inc : head_r;
  assign we    = cmd.ws_reset | cmd.ws_append | cmd.evict;
  assign wdata = cmd.evict ? char_r : in_char;

  always_comb begin
    waddr = head_r;
    if (cmd.ws_reset) begin
      waddr = '0;
    end else if (cmd.ws_append) begin
      waddr = tail;
    end
  end

  // Quote tracking for a non-whitespace byte.
  always_comb begin
    quote_upd = qawn_pkg::Q_NONE;
    case (quote_r)
      qawn_pkg::Q_DOUBLE: begin
        quote_upd = (char_r == qawn_pkg::CHAR_DQUOTE) ? qawn_pkg::Q_NONE : qawn_pkg::Q_DOUBLE;
      end
      qawn_pkg::Q_SINGLE: begin
        quote_upd = (char_r == qawn_pkg::CHAR_SQUOTE) ? qawn_pkg::Q_NONE : qawn_pkg::Q_SINGLE;
      end
      default: begin
        if (char_r == qawn_pkg::CHAR_DQUOTE) begin
          quote_upd = qawn_pkg::Q_DOUBLE;
        end else if (char_r == qawn_pkg::CHAR_SQUOTE) begin
          quote_upd = qawn_pkg::Q_SINGLE;
        end
      end
    endcase
  end

  assign char_has = !qawn_pkg::is_ws(char_r);

  always_comb begin
    quote_nxt = quote_r;
    seen_nxt  = seen_r;
    head_nxt  = head_r;
    cnt_nxt   = cnt_r;
    ov_nxt    = ov_r && !out_ready;
    oc_nxt    = oc_r;
    oh_nxt    = oh_r;
    ol_nxt    = ol_r;
    if (cmd.ws_reset) begin
      head_nxt = '0;
      cnt_nxt  = CW'(1);
    end
    if (cmd.ws_append) begin
      cnt_nxt = cnt_r + CW'(1);
    end
    if (cmd.pop || cmd.evict) begin
      head_nxt = head_inc;
      ov_nxt   = 1'b1;
      oc_nxt   = rdata;
      oh_nxt   = 1'b1;
      ol_nxt   = 1'b0;
    end
    if (cmd.pop) begin
      cnt_nxt = cnt_r - CW'(1);
    end
    if (cmd.emit) begin
      ov_nxt  = 1'b1;
      oc_nxt  = char_has ? qawn_pkg::to_lower(char_r) : '0;
      oh_nxt  = char_has;
      ol_nxt  = last_r;
      cnt_nxt = '0;
      if (char_has) begin
        seen_nxt  = 1'b1;
        quote_nxt = quote_upd;
      end
      if (last_r) begin
        seen_nxt  = 1'b0;
        quote_nxt = qawn_pkg::Q_NONE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      quote_r <= qawn_pkg::Q_NONE;
      seen_r  <= 1'b0;
      head_r  <= '0;
      cnt_r   <= '0;
      ov_r    <= 1'b0;
    end else begin
      quote_r <= quote_nxt;
      seen_r  <= seen_nxt;
      head_r  <= head_nxt;
      cnt_r   <= cnt_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      char_r <= in_char;
      last_r <= in_last;
    end
    oc_r <= oc_nxt;
    oh_r <= oh_nxt;
    ol_r <= ol_nxt;
  end

  assign sts.in_ws    = qawn_pkg::is_ws(in_char);
  assign sts.seen     = seen_r;
  assign sts.quoted   = (quote_r != qawn_pkg::Q_NONE);
  assign sts.cnt_zero = (cnt_r == '0);
  assign sts.cnt_one  = (cnt_r == CW'(1));
  assign sts.full     = (cnt_r == CW'(PEND_DEPTH));
  assign sts.push_ok  = !ov_r || out_ready;

  assign out_valid = ov_r;
  assign out_char  = oc_r;
  assign has_char  = oh_r;
  assign out_last  = ol_r;

endmodule

`default_nettype wire

// ===== rtl/quote_aware_whitespace_normalizer.sv =====
// A content byte is latched from its request in S_IDLE and loaded into the result register in
// S_CHAR; if whitespace is held, S_DRAIN first sends each held byte, oldest first. A new request
// is taken only in S_IDLE, so the next byte is not accepted until the last one is through, and
// a result still waiting at the output holds the controller. Whitespace is done in S_IDLE, or
// passes S_EVICT when it pushes out the oldest held byte or S_CHAR when it ends the string.
// Reset (rst_n low, synchronous) clears the control state; the whitespace RAM is not cleared.
`timescale 1ns / 1ps
`default_nettype none

// Top level of the quote-aware whitespace normalizer.
//
// Each request carries one byte of a string. Leading whitespace is dropped, letters A to Z are
// lowercased, and outside quotes a run of whitespace collapses to its last byte. Inside a
// double- or single-quoted span whitespace is kept as it is. Whitespace is never sent on its
// own: it is held in a small RAM-based queue and released only when a content byte follows,
// so trailing whitespace disappears. When a quoted run outgrows the queue, the oldest held
// byte is sent to make room. A final byte that is whitespace produces a bare end marker.
//
// The controller owns the sequencing. The datapath owns the quote and content state, the
// queue pointers, the RAM and the output register, which lets a finished result wait while
// the next request is taken.
module quote_aware_whitespace_normalizer #(
  parameter int PEND_DEPTH = qawn_pkg::PEND_DEPTH_DEF
) (
  input wire logic     clk,
  input wire logic     rst_n,
  qawn_in_if.sink      in_chan,
  qawn_out_if.source   out_chan
);

  qawn_pkg::cmd_t cmd;
  qawn_pkg::sts_t sts;

  qawn_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_last  (in_chan.in_last),
    .sts      (sts),
    .in_ready (in_chan.ready),
    .cmd      (cmd)
  );

  qawn_dp #(
    .PEND_DEPTH (PEND_DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .in_char   (in_chan.in_char),
    .in_last   (in_chan.in_last),
    .out_ready (out_chan.ready),
    .sts       (sts),
    .out_valid (out_chan.valid),
    .out_char  (out_chan.out_char),
    .has_char  (out_chan.has_char),
    .out_last  (out_chan.out_last)
  );

`ifndef ASSERT_OFF
  // The controller issues at most one output write per cycle.
  a_one_push: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.pop, cmd.evict, cmd.emit}))
    else $error("more than one output write in a cycle");

  // An output write never overruns a result that is still waiting.
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.pop || cmd.evict || cmd.emit) |-> sts.push_ok)
    else $error("output register overwritten");

  // A bare end marker always closes its string and carries a zero byte.
  a_marker: assert property (@(posedge clk) disable iff (!rst_n)
    (out_chan.valid && !out_chan.has_char) |-> (out_chan.out_last && out_chan.out_char == '0))
    else $error("malformed end marker");

  // The held-whitespace queue is never empty and full at once.
  a_queue: assert property (@(posedge clk) disable iff (!rst_n)
    !(sts.cnt_zero && sts.full))
    else $error("queue count out of range");
`endif

endmodule

`default_nettype wire
